// ===== rtl/core/ppte_pkg.sv =====
// ppte_pkg: shared codes, widths and saturating helpers for the trajectory evaluator
// no dependencies; imported by the core and its checker
package ppte_pkg;

  localparam int IN_W   = 112;
  localparam int OUT_W  = 424;
  localparam int TERMS  = 6;
  localparam int AXES   = 3;
  localparam int SEG_W  = 6;

  // func codes of an input beat
  localparam logic [1:0] FUNC_STAMP = 2'd0;
  localparam logic [1:0] FUNC_COEF  = 2'd1;
  localparam logic [1:0] FUNC_QUERY = 2'd2;
  localparam logic [1:0] FUNC_RSVD  = 2'd3;

  // configuration register indexes
  localparam logic CFG_POLY_ORDER = 1'b0;
  localparam logic CFG_NUM_POINTS = 1'b1;

  localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};

  // saturating 64-bit add
  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (!a[63] && !b[63] && s[63]) return S64_MAX;
    if (a[63] && b[63] && !s[63]) return S64_MIN;
    return s;
  endfunction

  // coefficient times a small weight (0..5), saturated
  function automatic logic signed [63:0] sat_scale(input logic signed [63:0] c,
                                                   input logic [2:0] k);
    logic signed [66:0] e;
    logic signed [66:0] p;
    e = 67'(c);
    case (k)
      3'd1:    p = e;
      3'd2:    p = e <<< 1;
      3'd3:    p = e + (e <<< 1);
      3'd4:    p = e <<< 2;
      3'd5:    p = e + (e <<< 2);
      default: p = '0;
    endcase
    if (p[66] && (p[65:63] != 3'b111)) return S64_MIN;
    if (!p[66] && (p[65:63] != 3'b000)) return S64_MAX;
    return p[63:0];
  endfunction

endpackage

// ===== rtl/core/ppte_ram.sv =====
// ppte_ram: generic single-write, single-read memory with registered read data
// no dependencies
module ppte_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== rtl/core/piecewise_poly_trajectory_eval.sv =====
// piecewise_poly_trajectory_eval: stamp/coef tables, binary segment search, Horner evaluation
// depends on ppte_pkg and ppte_ram
// sequence: stamp or coef write beats are accepted while idle; a query runs clamp and
//   search (at most floor(log2(n))+1 search steps), then one Horner pass per axis, cubic
//   or quintic, and waits in S_DONE while an earlier result is still stalled
// throughput: one query at a time; the single 32x32 multiplier (two passes per 64x32
//   product, low half then high half) paces each Horner multiply
// reset: asynchronous active low; clears control state and config (cubic, 2 points);
//   tables are not cleared and hold garbage until written
module piecewise_poly_trajectory_eval import ppte_pkg::*; #(
  parameter int MAX_POINTS     = 64,
  parameter int TIME_FRAC_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [0:0]       cfg_idx_i,
  input  logic [6:0]       cfg_data_i,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // func[1:0], point[7:2], term[10:8], axis[12:11], coef_value[76:13], time_value[108:77]
  input  logic [IN_W-1:0]  s_axis_tdata,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // time_used[31:0], pos_x, pos_y, pos_z, vel_x, vel_y, vel_z (64 each), segment[421:416]
  output logic [OUT_W-1:0] m_axis_tdata
);

  localparam int PW = $clog2(MAX_POINTS);
  localparam int CD = MAX_POINTS * TERMS * AXES;
  localparam int CW = $clog2(CD);
  localparam int SW = PW + 2;
  localparam int F  = TIME_FRAC_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_CLAMP_RD, S_CLAMP, S_SRCH, S_SRCH_CMP, S_SEG,
    S_CO_RD, S_CO_INIT, S_TERM, S_MUL, S_SCALE, S_ADD, S_DONE
  } state_e;

  state_e state_q;
  logic              poly_order_q;
  logic [6:0]        num_points_q;
  logic [31:0]       tv_q, t_q;
  logic signed [SW-1:0] left_q, right_q;
  logic [PW-1:0]     mid_q, seg_q;
  logic [2:0]        j_q;
  logic [1:0]        axis_q;
  logic [1:0]        mph_q;
  logic              msel_v_q;
  logic              neg_q;
  logic [63:0]       mag_q;
  logic [63:0]       pp_lo_q, pp_hi_q;
  logic [95:0]       rnd_q;
  logic signed [63:0] p_q, v_q, mp_q, mv_q, cs_q;
  logic signed [63:0] pos_q [AXES];
  logic signed [63:0] vel_q [AXES];
  logic              out_valid_q;
  logic [OUT_W-1:0]  out_q;

  // input beat fields
  logic [1:0]  in_func;
  logic [5:0]  in_point;
  logic [2:0]  in_term;
  logic [1:0]  in_axis;
  logic [63:0] in_coef;
  logic [31:0] in_time;
  assign in_func  = s_axis_tdata[1:0];
  assign in_point = s_axis_tdata[7:2];
  assign in_term  = s_axis_tdata[10:8];
  assign in_axis  = s_axis_tdata[12:11];
  assign in_coef  = s_axis_tdata[76:13];
  assign in_time  = s_axis_tdata[108:77];

  logic s_acc;
  assign s_axis_tready = (state_q == S_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  // waypoints in use minus one, saturated into 1..MAX_POINTS-1
  logic [PW-1:0] nm1;
  always_comb begin
    if (num_points_q < 7'd2) begin
      nm1 = PW'(1);
    end else if (32'(num_points_q) > MAX_POINTS) begin
      nm1 = PW'(MAX_POINTS - 1);
    end else begin
      nm1 = PW'(num_points_q - 7'd1);
    end
  end

  logic [2:0] nt;
  assign nt = poly_order_q ? 3'd6 : 3'd4;

  // table write decode
  logic stamp_we, coef_we;
  logic [CW-1:0] coef_waddr, coef_raddr;
  assign stamp_we = s_acc && (in_func == FUNC_STAMP) && (32'(in_point) < MAX_POINTS);
  assign coef_we  = s_acc && (in_func == FUNC_COEF) && (32'(in_point) < MAX_POINTS)
                    && (in_term < 3'd6) && (in_axis < 2'd3);
  assign coef_waddr = (CW'(in_point) << 4) + (CW'(in_point) << 1)
                      + CW'(in_term) + (CW'(in_term) << 1) + CW'(in_axis);
  assign coef_raddr = (CW'(seg_q) << 4) + (CW'(seg_q) << 1)
                      + CW'(j_q) + (CW'(j_q) << 1) + CW'(axis_q);

  // search midpoint
  logic signed [SW-1:0] mid_s;
  assign mid_s = left_q + ((right_q - left_q) >>> 1);

  logic        stamp_re;
  logic [PW-1:0] stamp_raddr;
  logic [31:0] stamp_rd;
  logic [63:0] coef_rd;
  logic        coef_re;
  assign stamp_re    = (state_q == S_CLAMP_RD) || (state_q == S_SRCH && left_q <= right_q);
  assign stamp_raddr = (state_q == S_CLAMP_RD) ? nm1 : PW'(mid_s);
  assign coef_re     = (state_q == S_CO_RD) || (state_q == S_TERM);

  ppte_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_stamp (
    .clk_i   (clk_i),
    .we_i    (stamp_we),
    .waddr_i (PW'(in_point)),
    .wdata_i (in_time),
    .re_i    (stamp_re),
    .raddr_i (stamp_raddr),
    .rdata_o (stamp_rd)
  );

  ppte_ram #(.WIDTH(64), .DEPTH(CD)) u_coef (
    .clk_i   (clk_i),
    .we_i    (coef_we),
    .waddr_i (coef_waddr),
    .wdata_i (in_coef),
    .re_i    (coef_re),
    .raddr_i (coef_raddr),
    .rdata_o (coef_rd)
  );

  // shared 32x32 multiplier, low then high half of the magnitude
  logic [63:0] mul_p;
  assign mul_p = 64'(mag_q[mph_q[0]*32 +: 32]) * 64'(t_q);

  // rounded, saturated product from the accumulated partials
  logic [63:0] r_mag;
  logic        r_over;
  logic signed [63:0] mul_res;
  assign r_mag  = rnd_q[F +: 64];
  assign r_over = (rnd_q >> (64 + F)) != '0;
  always_comb begin
    if (!neg_q) begin
      mul_res = (r_over || r_mag[63]) ? S64_MAX : r_mag;
    end else begin
      mul_res = (r_over || r_mag[63]) ? S64_MIN : -r_mag;
    end
  end

  // end of search: segment index
  logic signed [SW-1:0] seg_s;
  assign seg_s = (left_q > $signed(SW'(nm1))) ? $signed(SW'(nm1)) - SW'(1) : left_q - SW'(1);

  logic signed [63:0] p_add, v_add;
  logic               v_upd;
  assign p_add = sat_add(mp_q, coef_rd);
  assign v_add = sat_add(mv_q, cs_q);
  assign v_upd = (j_q <= nt - 3'd2);

  // sequencer, config and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      poly_order_q <= 1'b0;
      num_points_q <= 7'd2;
      out_valid_q  <= 1'b0;
      j_q          <= '0;
      axis_q       <= '0;
      mph_q        <= '0;
      msel_v_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_POLY_ORDER: poly_order_q <= cfg_data_i[0];
          CFG_NUM_POINTS: num_points_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_q && m_axis_tready && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (s_acc && in_func == FUNC_QUERY) begin
            tv_q    <= in_time;
            state_q <= S_CLAMP_RD;
          end
        end
        S_CLAMP_RD: state_q <= S_CLAMP;
        S_CLAMP: begin
          t_q     <= (tv_q > stamp_rd) ? stamp_rd : tv_q;
          left_q  <= '0;
          right_q <= $signed(SW'(nm1));
          state_q <= S_SRCH;
        end
        S_SRCH: begin
          if (left_q <= right_q) begin
            mid_q   <= PW'(mid_s);
            state_q <= S_SRCH_CMP;
          end else begin
            state_q <= S_SEG;
          end
        end
        S_SRCH_CMP: begin
          if (stamp_rd <= t_q) begin
            left_q <= $signed(SW'(mid_q)) + SW'(1);
          end else begin
            right_q <= $signed(SW'(mid_q)) - SW'(1);
          end
          state_q <= S_SRCH;
        end
        S_SEG: begin
          seg_q   <= seg_s[SW-1] ? '0 : PW'(seg_s);
          axis_q  <= '0;
          j_q     <= '0;
          state_q <= S_CO_RD;
        end
        S_CO_RD: state_q <= S_CO_INIT;
        S_CO_INIT: begin
          p_q     <= coef_rd;
          v_q     <= sat_scale(coef_rd, nt - 3'd1);
          j_q     <= 3'd1;
          state_q <= S_TERM;
        end
        S_TERM: begin
          neg_q    <= p_q[63];
          mag_q    <= p_q[63] ? -p_q : p_q;
          msel_v_q <= 1'b0;
          mph_q    <= '0;
          state_q  <= S_MUL;
        end
        S_MUL: begin
          // phase counter wraps to zero after the last phase
          mph_q <= mph_q + 2'd1;
          case (mph_q)
            2'd0: pp_lo_q <= mul_p;
            2'd1: pp_hi_q <= mul_p;
            2'd2: rnd_q   <= {pp_hi_q, 32'd0} + 96'(pp_lo_q) + (96'd1 << (F - 1));
            default: begin
              if (!msel_v_q) begin
                mp_q <= mul_res;
                if (v_upd) begin
                  msel_v_q <= 1'b1;
                  neg_q    <= v_q[63];
                  mag_q    <= v_q[63] ? -v_q : v_q;
                end else begin
                  state_q <= S_SCALE;
                end
              end else begin
                mv_q    <= mul_res;
                state_q <= S_SCALE;
              end
            end
          endcase
        end
        S_SCALE: begin
          cs_q    <= sat_scale(coef_rd, nt - 3'd1 - j_q);
          state_q <= S_ADD;
        end
        S_ADD: begin
          p_q <= p_add;
          if (v_upd) begin
            v_q <= v_add;
          end
          if (j_q == nt - 3'd1) begin
            pos_q[axis_q] <= p_add;
            vel_q[axis_q] <= v_q;
            j_q           <= '0;
            if (axis_q == 2'd2) begin
              state_q <= S_DONE;
            end else begin
              axis_q  <= axis_q + 2'd1;
              state_q <= S_CO_RD;
            end
          end else begin
            j_q     <= j_q + 3'd1;
            state_q <= S_TERM;
          end
        end
        S_DONE: begin
          if (!out_valid_q || m_axis_tready) begin
            out_q <= {2'd0, SEG_W'(seg_q), vel_q[2], vel_q[1], vel_q[0],
                      pos_q[2], pos_q[1], pos_q[0], t_q};
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/ppte_checker.sv =====
// ppte_checker: port-level assertions for the trajectory evaluator, bound to the top level
// depends on ppte_pkg and piecewise_poly_trajectory_eval
module ppte_checker import ppte_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic [IN_W-1:0]  s_axis_tdata,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata
);

  logic s_acc, s_write;
  assign s_acc   = s_axis_tvalid && s_axis_tready;
  assign s_write = s_acc && (s_axis_tdata[1:0] == FUNC_STAMP || s_axis_tdata[1:0] == FUNC_COEF);

  // a query beat keeps the block busy
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && s_axis_tdata[1:0] == FUNC_QUERY |=> !s_axis_tready)
    else $error("input ready right after a query beat");

  // the input is ready again right after a table write
  a_write_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_write |=> s_axis_tready)
    else $error("input not ready after a write beat");

  // a table write never produces a result beat
  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_write |=> !$rose(m_axis_tvalid))
    else $error("result beat after a write beat");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat dropped or changed while stalled");

endmodule

bind piecewise_poly_trajectory_eval ppte_checker u_ppte_checker (.*);
